// File: hw/rtl/mlpe_pkg.sv
package mlpe_pkg;

  // Network shape
  localparam int HIDDEN_ONE = 4;
  localparam int HIDDEN_TWO = 4;

  // Weight store layout, in load order
  localparam int OFS_L1     = 0;
  localparam int OFS_L2     = OFS_L1 + HIDDEN_ONE;
  localparam int OFS_L3     = OFS_L2 + HIDDEN_ONE * HIDDEN_TWO;
  localparam int OFS_B1     = OFS_L3 + HIDDEN_TWO;
  localparam int OFS_B2     = OFS_B1 + HIDDEN_ONE;
  localparam int OFS_B3     = OFS_B2 + HIDDEN_TWO;
  localparam int STORE_SIZE = OFS_B3 + 1;
  localparam int WADDR_W    = $clog2(STORE_SIZE);

  // Hidden value scratch: layer one values first, then layer two
  localparam int HID_DEPTH  = HIDDEN_ONE + HIDDEN_TWO;
  localparam int HADDR_W    = $clog2(HID_DEPTH);

  localparam int MAX_FANIN  = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
  localparam int CNT_W      = $clog2(MAX_FANIN + 1);

  // Q8.8 weight times Q16.16 input gives a Q24.24 product
  localparam int PROD_W     = 48;
  localparam int ACC_W      = PROD_W + $clog2(MAX_FANIN + 1);

  localparam logic [62:0] MAX63      = {63{1'b1}};
  localparam logic [32:0] SQRT_MAX63 = 33'd3037000499;
  localparam int          DIV_STEPS  = 63;

  // Item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Multiplier operand source
  typedef enum logic [1:0] {
    SRC_BIAS,
    SRC_X,
    SRC_HID
  } src_t;

  typedef struct packed {
    logic                    kind;
    logic [5:0]              weight_index;
    logic signed [15:0]      weight_value;
    logic signed [15:0]      x_value;
    logic signed [15:0]      target_value;
    logic                    last_sample;
  } item_t;

  typedef struct packed {
    logic signed [31:0]      net_out;
    logic [62:0]             sq_err;
    logic [62:0]             err_total;
    logic                    mean_valid;
    logic [62:0]             mean_err;
  } result_t;

  // One multiply-accumulate step issued by the sequencer
  typedef struct packed {
    logic                    valid;
    src_t                    src;
    logic                    first;
    logic                    last;
    logic                    final_op;
    logic [HADDR_W-1:0]      dest;
    logic [WADDR_W-1:0]      waddr;
    logic [HADDR_W-1:0]      haddr;
  } op_t;

endpackage

// File: hw/rtl/mlpe_wstore.sv
module mlpe_wstore (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [mlpe_pkg::WADDR_W-1:0]   waddr,
  input  logic signed [15:0]             wdata,
  input  logic [mlpe_pkg::WADDR_W-1:0]   raddr,
  output logic signed [15:0]             rdata
);
  import mlpe_pkg::*;

  logic signed [15:0]    mem [STORE_SIZE];
  logic signed [15:0]    mem_q;
  logic [STORE_SIZE-1:0] live;
  logic                  live_q;

  // Write one slot, read one slot with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // Track written slots; an unwritten slot reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      live   <= '0;
      live_q <= 1'b0;
    end else begin
      if (we) begin
        live[waddr] <= 1'b1;
      end
      live_q <= live[raddr];
    end
  end

  assign rdata = live_q ? mem_q : '0;

endmodule

// File: hw/rtl/mlpe_seq.sv
module mlpe_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            stall,
  output mlpe_pkg::op_t   op
);
  import mlpe_pkg::*;

  typedef enum logic [1:0] {
    LYR_ONE,
    LYR_TWO,
    LYR_OUT
  } layer_t;

  layer_t           layer;
  logic             running;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] fanin;
  logic [CNT_W-1:0] last_n;

  // Layer shape: weight terms per neuron (bias not counted) and last neuron index
  always_comb begin
    case (layer)
      LYR_ONE: begin
        fanin  = CNT_W'(1);
        last_n = CNT_W'(HIDDEN_ONE - 1);
      end
      LYR_TWO: begin
        fanin  = CNT_W'(HIDDEN_ONE);
        last_n = CNT_W'(HIDDEN_TWO - 1);
      end
      LYR_OUT: begin
        fanin  = CNT_W'(HIDDEN_TWO);
        last_n = '0;
      end
      default: begin
        fanin  = CNT_W'(1);
        last_n = '0;
      end
    endcase
  end

  // Build the current step: term zero is the bias, the rest are weights
  always_comb begin
    op          = '0;
    op.valid    = running;
    op.first    = (k == '0);
    op.last     = (k == fanin);
    op.final_op = (layer == LYR_OUT);
    op.src      = SRC_BIAS;
    case (layer)
      LYR_ONE: begin
        op.dest = HADDR_W'(int'(n));
        if (k == '0) begin
          op.waddr = WADDR_W'(OFS_B1 + int'(n));
        end else begin
          op.src   = SRC_X;
          op.waddr = WADDR_W'(OFS_L1 + int'(n));
        end
      end
      LYR_TWO: begin
        op.dest = HADDR_W'(HIDDEN_ONE + int'(n));
        if (k == '0) begin
          op.waddr = WADDR_W'(OFS_B2 + int'(n));
        end else begin
          op.src   = SRC_HID;
          op.waddr = WADDR_W'(OFS_L2 + int'(n) * HIDDEN_ONE + int'(k) - 1);
          op.haddr = HADDR_W'(int'(k) - 1);
        end
      end
      LYR_OUT: begin
        if (k == '0) begin
          op.waddr = WADDR_W'(OFS_B3);
        end else begin
          op.src   = SRC_HID;
          op.waddr = WADDR_W'(OFS_L3 + int'(k) - 1);
          op.haddr = HADDR_W'(HIDDEN_ONE + int'(k) - 1);
        end
      end
      default: begin
        op.valid = 1'b0;
      end
    endcase
  end

  // Advance term, neuron and layer counters on each issued step
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      layer   <= LYR_ONE;
      n       <= '0;
      k       <= '0;
    end else if (start) begin
      running <= 1'b1;
      layer   <= LYR_ONE;
      n       <= '0;
      k       <= '0;
    end else if (running && !stall) begin
      if (k != fanin) begin
        k <= k + 1'b1;
      end else begin
        k <= '0;
        if (n != last_n) begin
          n <= n + 1'b1;
        end else begin
          n <= '0;
          case (layer)
            LYR_ONE: layer <= LYR_TWO;
            LYR_TWO: layer <= LYR_OUT;
            default: begin
              layer   <= LYR_ONE;
              running <= 1'b0;
            end
          endcase
        end
      end
    end
  end

endmodule

// File: hw/rtl/mlpe_mac.sv
module mlpe_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  mlpe_pkg::op_t        cur,
  input  logic signed [15:0]   wdata,
  input  logic signed [15:0]   x_value,
  output logic                 hazard,
  output logic                 net_valid,
  output logic signed [31:0]   net
);
  import mlpe_pkg::*;

  logic signed [31:0]       hmem [HID_DEPTH];
  logic signed [31:0]       hid_q;
  op_t                      op1_next;
  op_t                      op1;
  op_t                      op2;
  op_t                      op3;
  logic                     issue;
  logic                     hwe;
  logic signed [31:0]       operand;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-32:0]        top_bits;
  logic signed [31:0]       res;

  function automatic logic writes_to(op_t o, logic [HADDR_W-1:0] a);
    return o.valid && o.last && !o.final_op && (o.dest == a);
  endfunction

  // Hold the step while a hidden value it needs is still in flight
  assign hazard = cur.valid && (cur.src == SRC_HID) &&
                  (writes_to(op1, cur.haddr) || writes_to(op2, cur.haddr) ||
                   writes_to(op3, cur.haddr));
  assign issue  = cur.valid && !hazard;

  // Tag the step entering the read stage; a held step enters as a bubble
  always_comb begin
    op1_next       = cur;
    op1_next.valid = issue;
  end

  // Select the multiplier input: one, x in Q16.16, or a hidden value
  always_comb begin
    case (op1.src)
      SRC_BIAS: operand = 32'sh0001_0000;
      SRC_X:    operand = {{8{x_value[15]}}, x_value, 8'h00};
      SRC_HID:  operand = hid_q;
      default:  operand = '0;
    endcase
  end

  assign prod_next = PROD_W'(wdata) * PROD_W'(operand);

  // Advance step tags through read, multiply and accumulate stages
  always_ff @(posedge clk) begin
    if (rst) begin
      op1 <= '0;
      op2 <= '0;
      op3 <= '0;
    end else begin
      op1 <= op1_next;
      op2 <= op1;
      op3 <= op2;
    end
  end

  // Register the product, then accumulate
  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (op2.valid) begin
      acc <= op2.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // Drop eight fraction bits toward minus infinity and saturate to Q16.16
  assign shifted  = acc >>> 8;
  assign top_bits = shifted[ACC_W-1:31];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      res = shifted[31:0];
    end else if (shifted[ACC_W-1]) begin
      res = {1'b1, 31'b0};
    end else begin
      res = {1'b0, {31{1'b1}}};
    end
  end

  // Write finished hidden values back, read the next step's operand
  assign hwe = op3.valid && op3.last && !op3.final_op;

  always_ff @(posedge clk) begin
    if (hwe) begin
      hmem[op3.dest] <= res;
    end
    hid_q <= hmem[cur.haddr];
  end

  assign net_valid = op3.valid && op3.last && op3.final_op;
  assign net       = res;

endmodule

// File: hw/rtl/mlpe_div.sv
module mlpe_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [62:0]  dividend,
  input  logic [15:0]  divisor,
  output logic         done,
  output logic [62:0]  quotient
);
  import mlpe_pkg::*;

  localparam int                STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [62:0]       quo;
  logic [15:0]       rem;
  logic [15:0]       dvs;
  logic [16:0]       trial;
  logic [16:0]       diff;
  logic              take;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, quo[62]};
  assign take  = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      // Flag the quotient for one cycle after the last step
      done <= busy && !start && (step == STEP_LAST);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo  <= {quo[61:0], take};
        rem  <= take ? diff[15:0] : trial[15:0];
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: hw/rtl/mlp_1_4_4_1_mse_evaluator_core.sv
// Load item: written into the weight memory at the transfer; no result.
// Sample item: its result follows the 33 multiply-accumulate steps that each take one read
// of the single weight-memory port, plus a short error tail; the next item can transfer
// once the result is posted.
// Last sample of a set: a bit-serial division of the error sum by the sample count follows.
// Reset (rst, synchronous): weight slots read as zero until loaded, sum and count clear.
module mlp_1_4_4_1_mse_evaluator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mlpe_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output mlpe_pkg::result_t   result
);
  import mlpe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_SQUARE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t               state;
  logic signed [15:0]   x_reg;
  logic signed [15:0]   target_reg;
  logic                 last_reg;
  logic signed [31:0]   net_reg;
  logic [32:0]          mag;
  logic [32:0]          mag_next;
  logic signed [32:0]   diff;
  logic [63:0]          sq_wide;
  logic [62:0]          sq_next;
  logic [62:0]          sq;
  logic [63:0]          sum_wide;
  logic [62:0]          sum_next;
  logic [62:0]          error_sum;
  logic [15:0]          count_next;
  logic [15:0]          sample_count;
  logic [62:0]          mean;
  logic                 accept;
  logic                 load_we;
  logic                 start;
  logic [WADDR_W-1:0]   load_addr;
  op_t                  cur;
  logic                 hazard;
  logic                 net_valid;
  logic signed [31:0]   net;
  logic signed [15:0]   wdata;
  logic                 div_start;
  logic                 div_done;
  logic [62:0]          quotient;

  // Input side: loads write the store directly, samples start the sequencer
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign load_we    = accept && (item.kind == KIND_LOAD) &&
                      (int'(item.weight_index) < STORE_SIZE);
  assign load_addr  = WADDR_W'(item.weight_index);
  assign start      = accept && (item.kind == KIND_SAMPLE);

  mlpe_wstore u_wstore (
    .clk   (clk),
    .rst   (rst),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (item.weight_value),
    .raddr (cur.waddr),
    .rdata (wdata)
  );

  mlpe_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stall (hazard),
    .op    (cur)
  );

  mlpe_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cur       (cur),
    .wdata     (wdata),
    .x_value   (x_reg),
    .hazard    (hazard),
    .net_valid (net_valid),
    .net       (net)
  );

  // Error magnitude: target in Q16.16 minus the network output
  assign diff     = (33'(target_reg) <<< 8) - 33'(net);
  assign mag_next = diff[32] ? 33'(-diff) : 33'(diff);

  // Square with saturation to the 63-bit range
  assign sq_wide = 64'(mag[31:0]) * 64'(mag[31:0]);
  assign sq_next = (mag > SQRT_MAX63) ? MAX63 : sq_wide[62:0];

  // Saturating running sum and sample count
  assign sum_wide   = {1'b0, error_sum} + {1'b0, sq};
  assign sum_next   = sum_wide[63] ? MAX63 : sum_wide[62:0];
  assign count_next = (&sample_count) ? sample_count : sample_count + 16'd1;

  assign div_start = (state == ST_SUM) && last_reg;

  mlpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (count_next),
    .done     (div_done),
    .quotient (quotient)
  );

  // Control sequence and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      error_sum    <= '0;
      sample_count <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            x_reg      <= item.x_value;
            target_reg <= item.target_value;
            last_reg   <= item.last_sample;
            state      <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (net_valid) begin
            net_reg <= net;
            mag     <= mag_next;
            state   <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          sq    <= sq_next;
          state <= ST_SUM;
        end
        ST_SUM: begin
          error_sum    <= sum_next;
          sample_count <= count_next;
          mean         <= '0;
          state        <= last_reg ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (div_done) begin
            mean  <= quotient;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid      <= 1'b1;
            result.net_out    <= net_reg;
            result.sq_err     <= sq;
            result.err_total  <= error_sum;
            result.mean_valid <= last_reg;
            result.mean_err   <= mean;
            if (last_reg) begin
              error_sum    <= '0;
              sample_count <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_net_in_run: assert property (@(posedge clk) disable iff (rst)
    net_valid |-> state == ST_RUN)
    else $error("network output finished outside the run phase");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_idle_no_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !cur.valid)
    else $error("sequencer issues steps while idle");

  a_sq_le_total: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.sq_err <= result.err_total)
    else $error("squared error exceeds running error sum");

  a_mean_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.mean_valid |-> result.mean_err == '0)
    else $error("mean field nonzero without mean flag");
`endif

endmodule

// File: bench/mlp_1_4_4_1_mse_evaluator_core_tb.sv
`timescale 1ns / 100ps

module mlp_1_4_4_1_mse_evaluator_core_tb;
  import mlpe_pkg::*;

  localparam int     RAND_ITEMS   = 950;
  localparam int     HOLD_CYCLES  = 600;
  localparam int     DRAIN_CYCLES = 200;
  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam longint Q16_MAX      = 64'sd2147483647;
  localparam longint Q16_MIN      = -64'sd2147483648;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  // Network state mirrored on the bench side
  logic signed [15:0] w_store [STORE_SIZE];
  logic [62:0]        sq_sum;
  logic [15:0]        set_count;

  result_t pending_results [$];

  bit calm;
  bit hold_req;
  int mismatches;
  int n_results;
  int n_samples;
  int n_sets;
  int n_loads;
  int n_sum_sat;

  mlp_1_4_4_1_mse_evaluator_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shift a Q24.24 sum down to Q16.16, floor rounding, then clamp to 32 bits
  function automatic longint q16_sat(input longint acc);
    longint v;
    v = acc >>> 8;
    if (v > Q16_MAX) return Q16_MAX;
    if (v < Q16_MIN) return Q16_MIN;
    return v;
  endfunction

  // Apply one item to the mirrored network; return 1 when it yields a result
  function automatic bit net_eval_step(input item_t it, output result_t r);
    longint      h1 [HIDDEN_ONE];
    longint      h2 [HIDDEN_TWO];
    longint      xin;
    longint      acc;
    longint      net;
    longint      diff;
    logic [63:0] mag;
    logic [63:0] sq;
    r = '0;
    if (it.kind == KIND_LOAD) begin
      if (it.weight_index < STORE_SIZE) w_store[it.weight_index] = it.weight_value;
      return 1'b0;
    end
    xin = longint'($signed(it.x_value)) * 256;
    for (int i = 0; i < HIDDEN_ONE; i++) begin
      acc = longint'(w_store[OFS_B1 + i]) * 65536 + longint'(w_store[OFS_L1 + i]) * xin;
      h1[i] = q16_sat(acc);
    end
    for (int i = 0; i < HIDDEN_TWO; i++) begin
      acc = longint'(w_store[OFS_B2 + i]) * 65536;
      for (int j = 0; j < HIDDEN_ONE; j++)
        acc += longint'(w_store[OFS_L2 + i * HIDDEN_ONE + j]) * h1[j];
      h2[i] = q16_sat(acc);
    end
    acc = longint'(w_store[OFS_B3]) * 65536;
    for (int j = 0; j < HIDDEN_TWO; j++)
      acc += longint'(w_store[OFS_L3 + j]) * h2[j];
    net = q16_sat(acc);

    // Squared error and saturating running sum
    diff = longint'($signed(it.target_value)) * 256 - net;
    mag  = (diff < 0) ? -diff : diff;
    sq   = (mag > SQRT_MAX63) ? {1'b0, MAX63} : mag * mag;
    if (sq_sum > MAX63 - sq[62:0]) begin
      sq_sum = MAX63;
      n_sum_sat++;
    end else begin
      sq_sum = sq_sum + sq[62:0];
    end
    if (set_count != 16'hFFFF) set_count++;

    r.net_out   = net[31:0];
    r.sq_err    = sq[62:0];
    r.err_total = sq_sum;
    if (it.last_sample) begin
      r.mean_valid = 1'b1;
      r.mean_err   = sq_sum / {47'd0, set_count};
      sq_sum       = '0;
      set_count    = '0;
    end
    return 1'b1;
  endfunction

  function automatic item_t mk_item(input logic kind, input logic [5:0] idx,
                                    input logic [15:0] w, input logic [15:0] x,
                                    input logic [15:0] t, input logic last);
    item_t it;
    it.kind         = kind;
    it.weight_index = idx;
    it.weight_value = w;
    it.x_value      = x;
    it.target_value = t;
    it.last_sample  = last;
    return it;
  endfunction

  function automatic result_t mk_res(input logic [31:0] net, input logic [62:0] sq,
                                     input logic [62:0] total, input logic mv,
                                     input logic [62:0] mean);
    result_t r;
    r.net_out    = net;
    r.sq_err     = sq;
    r.err_total  = total;
    r.mean_valid = mv;
    r.mean_err   = mean;
    return r;
  endfunction

  // Mostly small Q8.8 values, a quarter over the full range
  function automatic logic [15:0] rand_q88();
    int v;
    v = $urandom_range(0, 768);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(v - 384);
  endfunction

  function automatic item_t rand_item();
    logic [63:0] raw;
    item_t       it;
    raw = {$urandom, $urandom};
    it  = raw[$bits(item_t)-1:0];
    it.weight_value = rand_q88();
    it.x_value      = rand_q88();
    it.target_value = rand_q88();
    return it;
  endfunction

  // Offer one item, hold it until the transfer, then predict its result
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int      gap;
    result_t r;
    bit      got;
    gap = 0;
    if (!calm && $urandom_range(99) < 6) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    got = net_eval_step(it, r);
    if (got) begin
      pending_results.push_back(typed ? want : r);
      n_samples++;
      if (it.last_sample) n_sets++;
    end else if (it.weight_index < STORE_SIZE) begin
      n_loads++;
    end
  endtask

  // Receiver: random idling, a quiet stretch, and one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: net=%h sq=%h total=%h mv=%b mean=%h",
                   n_results, result.net_out, result.sq_err, result.err_total,
                   result.mean_valid, result.mean_err);
      end else begin
        want = pending_results.pop_front();
        if (want.net_out !== result.net_out || want.sq_err !== result.sq_err ||
            want.err_total !== result.err_total || want.mean_valid !== result.mean_valid ||
            want.mean_err !== result.mean_err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d: expected net=%h sq=%h total=%h mv=%b mean=%h,",
                     n_results, want.net_out, want.sq_err, want.err_total,
                     want.mean_valid, want.mean_err);
            $display("  got net=%h sq=%h total=%h mv=%b mean=%h",
                     result.net_out, result.sq_err, result.err_total,
                     result.mean_valid, result.mean_err);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycles, pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    dir_row_t dir_table [$];
    item_t    it;
    int       rand_items;
    int       n;
    bit       open_set;
    bit       hold_done;

    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    mismatches = 0;
    n_results  = 0;
    n_samples  = 0;
    n_sets     = 0;
    n_loads    = 0;
    n_sum_sat  = 0;
    for (int i = 0; i < STORE_SIZE; i++) w_store[i] = '0;
    sq_sum    = '0;
    set_count = '0;

    // Empty store: output is zero, error is the target alone
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h7FFF, 16'h0000, 1'b0), 1'b1,
                          mk_res(32'h0, 63'h0, 63'h0, 1'b0, 63'h0)});
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h8000, 16'h8000, 1'b1), 1'b1,
                          mk_res(32'h0, 63'h4000_0000_0000, 63'h4000_0000_0000, 1'b1,
                                 63'h2000_0000_0000)});
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h0000, 16'h7FFF, 1'b1), 1'b1,
                          mk_res(32'h0, 63'h3FFF_0001_0000, 63'h3FFF_0001_0000, 1'b1,
                                 63'h3FFF_0001_0000)});
    // Out-of-range slots are dropped, so the store stays empty
    dir_table.push_back('{mk_item(KIND_LOAD, 6'd33, 16'h7FFF, 16'h0, 16'h0, 1'b0), 1'b0, '0});
    dir_table.push_back('{mk_item(KIND_LOAD, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1),
                          1'b0, '0});
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h0064, 16'h0000, 1'b1), 1'b1,
                          mk_res(32'h0, 63'h0, 63'h0, 1'b1, 63'h0)});
    // Output bias alone at both extremes
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_B3), 16'h7FFF, 16'h0, 16'h0, 1'b0), 1'b0,
                          '0});
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h0000, 16'h7FFF, 1'b1), 1'b1,
                          mk_res(32'h007F_FF00, 63'h0, 63'h0, 1'b1, 63'h0)});
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_B3), 16'h8000, 16'h0, 16'h0, 1'b0), 1'b0,
                          '0});
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h1234, 16'h8000, 1'b1), 1'b1,
                          mk_res(32'hFF80_0000, 63'h0, 63'h0, 1'b1, 63'h0)});
    // Full-scale chain through the first neuron of each layer: output saturates
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_L1), 16'h7FFF, 16'h0, 16'h0, 1'b0), 1'b0,
                          '0});
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_L2), 16'h7FFF, 16'h0, 16'h0, 1'b0), 1'b0,
                          '0});
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_L3), 16'h7FFF, 16'h0, 16'h0, 1'b0), 1'b0,
                          '0});
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_B3), 16'h0000, 16'h0, 16'h0, 1'b0), 1'b0,
                          '0});
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h7FFF, 16'h8000, 1'b0),
                          1'b0, '0});
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h8000, 16'h7FFF, 1'b0),
                          1'b0, '0});
    // Error sum is pinned at its ceiling by now
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h7FFF, 16'h8000, 1'b1),
                          1'b0, '0});
    // Hidden biases, and the last slot of the layer-two bias and weight groups
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_B1), 16'h8000, 16'h0, 16'h0, 1'b0), 1'b0,
                          '0});
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_B2), 16'h3039, 16'h0, 16'h0, 1'b0), 1'b0,
                          '0});
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_B2 + HIDDEN_TWO - 1), 16'hC000, 16'h0,
                                  16'h0, 1'b0), 1'b0, '0});
    dir_table.push_back('{mk_item(KIND_LOAD, 6'(OFS_L3 - 1), 16'h0100, 16'h0, 16'h0, 1'b0),
                          1'b0, '0});
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'hFFFF, 16'h0001, 1'b0),
                          1'b0, '0});
    dir_table.push_back('{mk_item(KIND_SAMPLE, 6'd0, 16'h0000, 16'h0100, 16'hFF00, 1'b1),
                          1'b0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) send_item(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);

    // Random sets: reload some weights, then run a set of samples
    rand_items = 0;
    hold_done  = 1'b0;
    while (rand_items < RAND_ITEMS) begin
      calm = (rand_items >= 300 && rand_items < 450);
      if (!hold_done && rand_items >= 600) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end

      if ($urandom_range(9) == 0) begin
        for (int s = 0; s < STORE_SIZE; s++) begin
          it = rand_item();
          it.kind = KIND_LOAD;
          it.weight_index = 6'(s);
          send_item(it, 1'b0, '0);
          rand_items++;
        end
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) begin
          it = rand_item();
          it.kind = KIND_LOAD;
          it.weight_index = 6'($urandom_range(0, STORE_SIZE - 1));
          send_item(it, 1'b0, '0);
          rand_items++;
        end
      end

      // Stray writes beyond the store
      if ($urandom_range(7) == 0) begin
        it = rand_item();
        it.kind = KIND_LOAD;
        it.weight_index = 6'($urandom_range(STORE_SIZE, 63));
        send_item(it, 1'b0, '0);
      end

      // Sample set; now and then leave it open across the next reload
      n = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 10);
      open_set = ($urandom_range(5) == 0);
      for (int k = 0; k < n; k++) begin
        it = rand_item();
        it.kind = KIND_SAMPLE;
        it.last_sample = (k == n - 1) && !open_set;
        send_item(it, 1'b0, '0);
        rand_items++;
      end
    end

    // Close any open set so the last mean is checked too
    it = rand_item();
    it.kind = KIND_SAMPLE;
    it.last_sample = 1'b1;
    send_item(it, 1'b0, '0);
    item_valid <= 1'b0;
    calm = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d samples in %0d sets with %0d weight loads; %0d results checked,",
             n_samples, n_sets, n_loads, n_results);
    $display("error sum hit its ceiling %0d times; %0d mismatches", n_sum_sat, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
